// ===== hdl/disjoint_sparse_range_query_core_macros.svh =====
// Assertion macros shared by the disjoint sparse range query block.
// Depends on nothing; included by modules that carry assertions.
`ifndef DISJOINT_SPARSE_RANGE_QUERY_CORE_MACROS_SVH
`define DISJOINT_SPARSE_RANGE_QUERY_CORE_MACROS_SVH
// implication checked on every edge outside reset
`define DSRQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define DSRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== hdl/dsrq_pkg.sv =====
// Package for the disjoint sparse range query block: sizes, codes, combine op.
// No dependencies.
package dsrq_pkg;
	localparam int MaxElements = 1024;
	localparam int MaxLevels   = 10;
	localparam int ValueWidth  = 32;
	localparam int PosW  = $clog2(MaxElements);
	localparam int LenW  = PosW + 1;
	localparam int LvlW  = $clog2(MaxLevels);
	localparam int AddrW = $clog2(MaxLevels * MaxElements);

	typedef logic [ValueWidth-1:0] value_t;
	typedef logic [PosW-1:0] pos_t;
	typedef logic [LenW-1:0] len_t;
	typedef logic [LvlW-1:0] lvl_t;
	typedef logic [AddrW-1:0] addr_t;

	localparam logic [1:0] OpLoad  = 2'd0;
	localparam logic [1:0] OpBuild = 2'd1;
	localparam logic [1:0] OpQuery = 2'd2;

	localparam logic [2:0] ModeMin = 3'd1;
	localparam logic [2:0] ModeMax = 3'd2;
	localparam logic [2:0] ModeXor = 3'd3;
	localparam logic [2:0] ModeAnd = 3'd4;
	localparam logic [2:0] ModeOr  = 3'd5;

	localparam logic RegLength = 1'b0;
	localparam logic RegMode   = 1'b1;

	// datapath write source
	typedef enum logic [1:0] {
		WSRC_ID   = 2'd0,
		WSRC_RAW  = 2'd1,
		WSRC_COMB = 2'd2,
		WSRC_LOAD = 2'd3
	} wsrc_t;

	typedef struct packed {
		logic  rd_en;
		addr_t rd_addr;
		logic  wr_en;
		addr_t wr_addr;
		wsrc_t wsrc;
		logic  cap_a;     // latch read data into operand a
		logic  cap_b;     // latch write data into chain register
		logic  res_id;    // result := identity
		logic  res_zero;  // result := 0
		logic  res_a;     // result := read data
		logic  res_comb;  // result := combine(a, read data)
	} dp_cmd_t;

	function automatic value_t identity_of(input logic [2:0] mode);
		return (mode == ModeMin || mode == ModeAnd) ? '1 : '0;
	endfunction

	function automatic value_t combine(input logic [2:0] mode, input value_t a,
			input value_t b);
		value_t r;
		case (mode)
			ModeMin: r = (a < b) ? a : b;
			ModeMax: r = (a > b) ? a : b;
			ModeXor: r = a ^ b;
			ModeAnd: r = a & b;
			ModeOr:  r = a | b;
			default: r = a + b;
		endcase
		return r;
	endfunction

	function automatic addr_t addr_of(input lvl_t l, input pos_t p);
		return AddrW'(l) * AddrW'(MaxElements) + AddrW'(p);
	endfunction
endpackage

// ===== hdl/dsrq_datapath.sv =====
// Datapath: table memory, operand registers, combine unit, result register.
// Depends on dsrq_pkg.
module dsrq_datapath (
	input  logic              clk,
	input  dsrq_pkg::dp_cmd_t cmd,
	input  logic [2:0]        mode,
	input  dsrq_pkg::value_t  load_value,
	output dsrq_pkg::value_t  result
);
	import dsrq_pkg::*;

	value_t mem [MaxLevels*MaxElements];
	value_t rdata_q, a_q, chain_q, res_q, wdata;

	always_comb begin
		case (cmd.wsrc)
			WSRC_ID:   wdata = identity_of(mode);
			WSRC_RAW:  wdata = rdata_q;
			WSRC_COMB: wdata = combine(mode, rdata_q, chain_q);
			default:   wdata = load_value;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) mem[cmd.wr_addr] <= wdata;
		if (cmd.rd_en) rdata_q <= mem[cmd.rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_a) a_q <= rdata_q;
		if (cmd.cap_b) chain_q <= wdata;
		if (cmd.res_id) res_q <= identity_of(mode);
		else if (cmd.res_zero) res_q <= '0;
		else if (cmd.res_a) res_q <= rdata_q;
		else if (cmd.res_comb) res_q <= combine(mode, a_q, rdata_q);
	end

	assign result = res_q;
endmodule

// ===== hdl/dsrq_ctrl.sv =====
// Controller: handshakes, query address generation, build sequencer.
// Depends on dsrq_pkg and the assertion macro header.
`include "disjoint_sparse_range_query_core_macros.svh"
module dsrq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        opcode,
	input  dsrq_pkg::pos_t    load_index,
	input  dsrq_pkg::len_t    range_left,
	input  dsrq_pkg::len_t    range_right,
	input  dsrq_pkg::len_t    array_length,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              status,
	output dsrq_pkg::dp_cmd_t cmd
);
	import dsrq_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_QRD1  = 10'b0000000010,
		S_QRD2  = 10'b0000000100,
		S_QFIN  = 10'b0000001000,
		S_OUT   = 10'b0000010000,
		S_BLV   = 10'b0000100000,
		S_BFILL = 10'b0001000000,
		S_BRD   = 10'b0010000000,
		S_BWAIT = 10'b0100000000,
		S_BWR   = 10'b1000000000
	} state_t;

	state_t state_q;
	len_t   n_q, j_q, k_q, half_q, cnt_q;
	lvl_t   lv_q, levels_q;
	pos_t   qb_q;
	lvl_t   qu_q;
	logic   qsingle_q, status_q, dir_q;  // dir 0 suffix, 1 prefix
	logic   accept;
	len_t   n_eff, x, nm1;
	lvl_t   tb, tbn;
	pos_t   bpos;

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE) || (state_q == S_OUT && out_ready);
	assign out_valid = (state_q == S_OUT);
	assign status = status_q;
	assign n_eff = (array_length > len_t'(MaxElements)) ? len_t'(MaxElements) : array_length;
	assign x = range_left ^ (range_right - 1'b1);
	assign nm1 = n_eff - 1'b1;

	always_comb begin
		tb = '0;
		tbn = '0;
		for (int i = 1; i < LenW; i++) begin
			if (x[i]) tb = lvl_t'(i);
			if (nm1[i]) tbn = lvl_t'(i);
		end
	end

	// build position: suffix goes down from j-1, prefix goes up from j
	assign bpos = dir_q ? pos_t'(j_q + k_q) : pos_t'(j_q - k_q - 1'b1);

	always_comb begin
		cmd = '0;
		cmd.wsrc = WSRC_ID;
		case (state_q)
			S_IDLE, S_OUT: begin
				if (accept && opcode == OpLoad) begin
					cmd.wr_en = 1'b1;
					cmd.wsrc = WSRC_LOAD;
					cmd.wr_addr = addr_of('0, load_index);
				end
				if (accept && opcode == OpQuery) begin
					cmd.rd_en = 1'b1;
					cmd.rd_addr = (range_left + 1'b1 == range_right)
						? addr_of('0, pos_t'(range_left)) : addr_of(tb, pos_t'(range_left));
				end
				if (accept && !(opcode == OpQuery && range_left <= range_right &&
						range_right <= n_eff && range_left != range_right))
					begin
					cmd.res_zero = 1'b1;
					cmd.res_id = (opcode == OpQuery && range_left == range_right &&
						range_right <= n_eff);
				end
			end
			S_QRD1: begin
				// first read word is on rdata_q now
				cmd.rd_en = 1'b1;
				cmd.rd_addr = addr_of(qu_q, qb_q);
				cmd.cap_a = 1'b1;
			end
			S_QRD2: begin
				cmd.res_a = qsingle_q;
			end
			S_QFIN: cmd.res_comb = 1'b1;
			S_BFILL: begin
				cmd.wr_en = 1'b1;
				cmd.wr_addr = addr_of(lv_q, pos_t'(cnt_q));
			end
			S_BRD: begin
				cmd.rd_en = 1'b1;
				cmd.rd_addr = addr_of('0, bpos);
			end
			S_BWR: begin
				cmd.wr_en = 1'b1;
				cmd.wr_addr = addr_of(lv_q, bpos);
				cmd.wsrc = (k_q == '0) ? WSRC_RAW : WSRC_COMB;
				cmd.cap_b = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			status_q <= 1'b0;
			n_q <= '0; j_q <= '0; k_q <= '0; half_q <= '0; cnt_q <= '0;
			lv_q <= '0; levels_q <= '0; qb_q <= '0; qu_q <= '0;
			qsingle_q <= 1'b0; dir_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE, S_OUT: begin
					if (accept) begin
						status_q <= 1'b0;
						state_q <= S_OUT;
						if (opcode == OpQuery) begin
							if (range_left > range_right || range_right > n_eff)
								status_q <= 1'b1;
							else if (range_left != range_right) begin
								qsingle_q <= (range_left + 1'b1 == range_right);
								qu_q <= tb;
								qb_q <= pos_t'(range_right - 1'b1);
								state_q <= S_QRD1;
							end
						end else if (opcode == OpBuild && n_eff >= len_t'(2) && tbn != '0) begin
							n_q <= n_eff;
							levels_q <= tbn;
							lv_q <= lvl_t'(1);
							state_q <= S_BLV;
						end
					end else if (state_q == S_OUT && out_ready)
						state_q <= S_IDLE;
				end
				S_QRD1: state_q <= S_QRD2;
				S_QRD2: state_q <= qsingle_q ? S_OUT : S_QFIN;
				S_QFIN: state_q <= S_OUT;
				S_BLV: begin
					half_q <= len_t'(1) << lv_q;
					j_q <= len_t'(1) << lv_q;
					cnt_q <= '0;
					state_q <= S_BFILL;
				end
				S_BFILL: begin
					if (cnt_q + 1'b1 >= n_q) begin
						k_q <= '0; dir_q <= 1'b0;
						state_q <= (j_q < n_q) ? S_BRD : S_OUT;
					end else cnt_q <= cnt_q + 1'b1;
				end
				S_BRD: state_q <= S_BWAIT;
				S_BWAIT: state_q <= S_BWR;
				S_BWR: begin
					if (!dir_q) begin
						if (k_q + 1'b1 < half_q) begin
							k_q <= k_q + 1'b1; state_q <= S_BRD;
						end else begin
							k_q <= '0; dir_q <= 1'b1; state_q <= S_BRD;
						end
					end else if (k_q + 1'b1 < half_q && j_q + k_q + 1'b1 < n_q) begin
						k_q <= k_q + 1'b1; state_q <= S_BRD;
					end else if (j_q + (half_q << 1) < n_q) begin
						j_q <= j_q + (half_q << 1);
						k_q <= '0; dir_q <= 1'b0; state_q <= S_BRD;
					end else if (lv_q < levels_q) begin
						lv_q <= lv_q + 1'b1; state_q <= S_BLV;
					end else state_q <= S_OUT;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`DSRQ_ASSERT_IMP(a_onehot, clk, arst_n, 1'b1, $onehot(state_q), "state not one-hot")
	`DSRQ_ASSERT_IMP(a_wr_rd, clk, arst_n, cmd.wr_en && state_q == S_BWR, !cmd.rd_en,
		"build write collides with read")
	`DSRQ_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status),
		"result dropped")
	`DSRQ_ASSERT_IMP(a_lvl, clk, arst_n, state_q == S_BFILL, lv_q != '0 && lv_q < lvl_t'(MaxLevels),
		"build level out of range")
endmodule

// ===== hdl/disjoint_sparse_range_query_core.sv =====
// Channel  | handshake           | payload
// in       | in_valid/in_ready   | opcode load_index load_value range_left range_right
// out      | out_valid/out_ready | combined_value status
// cfg      | cfg_we              | cfg_index cfg_data
// Load writes the table on acceptance, then returns a result; a query reads the table at most twice.
// Build walks each level: a setup step, an identity fill of n entries, then a read, wait and write per entry.
// Reset clears control and configuration only; the table is undefined until loaded and built.
// A new word is taken in the cycle its predecessor's result is taken.
module disjoint_sparse_range_query_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            opcode,
	input  dsrq_pkg::pos_t        load_index,
	input  dsrq_pkg::value_t      load_value,
	input  dsrq_pkg::len_t        range_left,
	input  dsrq_pkg::len_t        range_right,
	output logic                  out_valid,
	input  logic                  out_ready,
	output dsrq_pkg::value_t      combined_value,
	output logic                  status,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [10:0]           cfg_data
);
	import dsrq_pkg::*;

	len_t       len_q;
	logic [2:0] mode_q;
	dp_cmd_t    cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			mode_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == RegLength) len_q <= cfg_data;
			else mode_q <= cfg_data[2:0];
		end
	end

	dsrq_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .opcode, .load_index,
		.range_left, .range_right, .array_length(len_q),
		.out_valid, .out_ready, .status, .cmd
	);

	dsrq_datapath u_dp (
		.clk, .cmd, .mode(mode_q), .load_value, .result(combined_value)
	);
endmodule
